// ===== hw/rtl/div128_pkg.sv =====
// Shared types and constants for the 128-by-128-bit restoring divider.
// Holds the input and result beat structs; no dependencies.
`timescale 1ns / 1ps

package div128_pkg;

	localparam int unsigned HALF_W  = 64;
	localparam int unsigned WORD_W  = 2 * HALF_W;
	localparam int unsigned STEPS   = WORD_W;
	localparam int unsigned CNT_W   = $clog2(STEPS);

	// Sequencer state codes.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic [HALF_W-1:0] dividend_hi;
		logic [HALF_W-1:0] dividend_lo;
		logic [HALF_W-1:0] divisor_hi;
		logic [HALF_W-1:0] divisor_lo;
	} div_in_t;

	typedef struct packed {
		logic [HALF_W-1:0] quotient_hi;
		logic [HALF_W-1:0] quotient_lo;
		logic              div_by_zero;
	} div_out_t;

endpackage

// ===== hw/rtl/div_128_by_128_restoring_core.sv =====
// Unsigned 128-by-128-bit restoring divider with one shared compare-subtract unit.
// Depends on div128_pkg for the beat structs and sequencer codes.
`timescale 1ns / 1ps

// How to use this block
// ---------------------
// The input channel (in_valid, in_ready, in_data) carries one beat holding a
// 128-bit unsigned dividend and a 128-bit unsigned divisor, each as two 64-bit
// halves. The result channel (out_valid, out_ready, out_data) returns one beat
// per input beat with the 128-bit quotient floor(dividend / divisor).
// A zero divisor gives an all-ones quotient with div_by_zero set.
// Each beat is worked through by a single 129-bit compare-subtract unit that
// produces one quotient bit per cycle over 128 iterations; the finished
// quotient is then handed to the output register. A zero divisor bypasses
// the iterations and goes straight to the hand-off to the output register.
// in_ready is high only while the unit is free, so a new beat is not accepted
// until the previous quotient has been handed to the output register.
// The result sits in an output register, so a new beat may be accepted while
// the previous result is still waiting to be taken. If the receiver stalls
// and the output register is still full when the next quotient is finished,
// the sequencer holds that quotient until the register frees up.
// An asynchronous reset (arst_n low) empties the output register and returns
// the sequencer to idle; any beat in flight is dropped.
module div_128_by_128_restoring_core
	import div128_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  div_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output div_out_t out_data
);

	logic [1:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	// The dividend shifts out of the top of num_q while quotient bits shift in
	// at the bottom, so after the last step num_q holds the quotient.
	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] den_q;
	logic [WORD_W-1:0] rem_q;
	logic              zero_q;

	div_out_t          out_q;
	logic              out_valid_q;

	logic              in_fire;
	logic              out_free;
	logic [WORD_W:0]   rem_sh;
	logic [WORD_W+1:0] diff;
	logic              take;
	logic              den_zero;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign den_zero  = ({in_data.divisor_hi, in_data.divisor_lo} == '0);

	// The shared unit: shift in the next dividend bit, keeping the bit that
	// falls off the top of the remainder, then trial-subtract the divisor.
	// The extra top bit of diff is the borrow; no borrow means the divisor fits.
	always_comb begin
		rem_sh = {rem_q, num_q[WORD_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		take   = !diff[WORD_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q   <= '0;
						state_q <= den_zero ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			num_q  <= {in_data.dividend_hi, in_data.dividend_lo};
			den_q  <= {in_data.divisor_hi, in_data.divisor_lo};
			rem_q  <= '0;
			zero_q <= den_zero;
		end else if (state_q == ST_RUN) begin
			// A restored remainder is always below the divisor, so 128 bits hold it.
			rem_q <= take ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			num_q <= {num_q[WORD_W-2:0], take};
		end
	end

	// Output register: parts the sequencer from a stalled receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			if (zero_q) begin
				out_q.quotient_hi <= '1;
				out_q.quotient_lo <= '1;
			end else begin
				out_q.quotient_hi <= num_q[WORD_W-1:HALF_W];
				out_q.quotient_lo <= num_q[HALF_W-1:0];
			end
			out_q.div_by_zero <= zero_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hw/rtl/div128_checker.sv =====
// Port-level checker for the restoring divider, bound to the top level.
// Depends on div128_pkg for the beat structs.
`timescale 1ns / 1ps

module div128_checker
	import div128_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input div_in_t  in_data,
	input logic     out_valid,
	input logic     out_ready,
	input div_out_t out_data
);

	// The unit is busy for the whole division once a beat is taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after an input beat was accepted");

	// No result can appear in the cycle straight after an acceptance.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result appeared immediately after an input beat");

	// A divide-by-zero result always carries an all-ones quotient.
	a_zero_all_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.div_by_zero) |->
			((&out_data.quotient_hi) && (&out_data.quotient_lo)))
		else $error("divide-by-zero beat without an all-ones quotient");

	// A stalled result beat is held unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result beat dropped or changed");

endmodule

bind div_128_by_128_restoring_core div128_checker u_div128_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
